// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue_top and the testbench.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int COUNT_OUT_W = 4;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Per-cycle control for each cell: broadcast command plus its own occupancy
    typedef struct packed {
        logic ins;       // accepted insert with room
        logic del;       // accepted delete with data
        logic occupied;  // this cell holds a stored entry
    } t_cell_ctrl;

endpackage

// File: design/spq_cell.sv
// One slot of the sorted shift chain: holds an entry, compares it with the
// new entry and moves data to or from its neighbors. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                                i_clk,
    input  spq_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_new_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_new_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_left_prio,
    input  logic                                i_left_lower,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_right_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_right_prio,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   o_prio,
    output logic                                o_lower
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] r_value, n_value;
    logic signed [PRIO_W-1:0]  r_prio, n_prio;
    logic                      w_stays;

    // Keep place when stored entry outranks or ties the new one
    assign w_stays = i_ctrl.occupied && (r_prio >= i_new_prio);
    assign o_lower = i_ctrl.occupied && !(r_prio >= i_new_prio);

    // Select shift-down, insert, shift-up or hold
    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.ins) begin
            if (i_left_lower) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else if (!w_stays) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end else if (i_ctrl.del) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

// File: design/sorted_priority_queue_top.sv
// Sorted priority queue: a chain of DEPTH spq_cell slots plus count and
// result registers. Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake          Ports
// command   in         start & !busy      i_cmd, i_item_value, i_item_priority
// result    out        o_strobe (1 cycle) o_status, o_out_value, o_out_priority,
//                                         o_entry_count
//
// Every request is handled at its accepting edge: all cells shift in parallel at
// that edge and the result shows on the next cycle, so one request per
// cycle is taken and busy stays low. Reset is synchronous, active low, and
// clears the entry count and the strobe; slot contents are not reset. The
// receiver cannot stall; each result is valid for exactly one cycle.

module sorted_priority_queue_top #(
    parameter int DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_item_priority,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [spq_pkg::COUNT_OUT_W-1:0]     o_entry_count
);
    import spq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CNT_W    = (CNT_BITS < COUNT_OUT_W) ? COUNT_OUT_W : CNT_BITS;

    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_strobe;
    t_status                   r_status, n_status;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic signed [PRIO_W-1:0]  r_out_prio, n_out_prio;

    logic w_accept, w_ins_ok, w_del_ok, w_full, w_empty;

    logic signed [VALUE_W-1:0] w_val   [DEPTH];
    logic signed [PRIO_W-1:0]  w_prio  [DEPTH];
    logic                      w_lower [DEPTH];

    // Decode the request
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_ins_ok = w_accept && (i_cmd == CMD_INSERT) && !w_full;
    assign w_del_ok = w_accept && (i_cmd == CMD_DELETE) && !w_empty;

    // Build the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctrl                w_ctrl;
        logic signed [VALUE_W-1:0] w_lv, w_rv;
        logic signed [PRIO_W-1:0]  w_lp, w_rp;
        logic                      w_ll;

        assign w_ctrl.ins      = w_ins_ok;
        assign w_ctrl.del      = w_del_ok;
        assign w_ctrl.occupied = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_lv = '0;
            assign w_lp = '0;
            assign w_ll = 1'b0;
        end else begin : g_mid
            assign w_lv = w_val[g-1];
            assign w_lp = w_prio[g-1];
            assign w_ll = w_lower[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rv = '0;
            assign w_rp = '0;
        end else begin : g_body
            assign w_rv = w_val[g+1];
            assign w_rp = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_new_value   (i_item_value),
            .i_new_prio    (i_item_priority),
            .i_left_value  (w_lv),
            .i_left_prio   (w_lp),
            .i_left_lower  (w_ll),
            .i_right_value (w_rv),
            .i_right_prio  (w_rp),
            .o_value       (w_val[g]),
            .o_prio        (w_prio[g]),
            .o_lower       (w_lower[g])
        );
    end

    // Form next count and result
    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_out_value = '0;
        n_out_prio  = '0;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del_ok) begin
            n_count     = r_count - CNT_W'(1);
            n_out_value = w_val[0];
            n_out_prio  = w_prio[0];
        end else if (i_cmd == CMD_INSERT) begin
            n_status = ST_OVERFLOW;
        end else begin
            n_status = ST_UNDERFLOW;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_value <= n_out_value;
            r_out_prio  <= n_out_prio;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_entry_count  = r_count[COUNT_OUT_W-1:0];

`ifndef ASSERT_OFF
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("count did not advance on insert");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("no result after accepted request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_strobe)
        else $error("result without request");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_UNDERFLOW)) |-> (r_count == '0))
        else $error("underflow reported with stored entries");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_OVERFLOW)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("overflow reported with room left");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for sorted_priority_queue_top: directed corner requests,
// then random insert/delete runs, checked against a shadow queue. Depends on spq_pkg.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH = 8;

    typedef struct {
        t_cmd                      cmd;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        int                        gap;          // idle cycles before this request
        bit                        drain_first;  // hold until every answer is back
    } t_queue_request;

    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [COUNT_OUT_W-1:0]    count;
    } t_queue_answer;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              i_cmd = 1'b0;
    logic signed [VALUE_W-1:0]         i_item_value = '0;
    logic signed [PRIO_W-1:0]          i_item_priority = '0;
    logic                              o_strobe;
    logic [1:0]                        o_status;
    logic signed [VALUE_W-1:0]         o_out_value;
    logic signed [PRIO_W-1:0]          o_out_priority;
    logic [COUNT_OUT_W-1:0]            o_entry_count;

    // Shadow copy of the queue contents, head in slot 0
    logic signed [VALUE_W-1:0] held_value [DEPTH];
    logic signed [PRIO_W-1:0]  held_prio  [DEPTH];
    int                        held_count = 0;

    t_queue_request request_q[$];
    t_queue_answer  answer_q[$];
    t_queue_request drv_item;
    bit             have_item = 1'b0;
    int             gap_left = 0;
    int             issued_count = 0;
    int             answered_count = 0;
    int             error_count = 0;
    int             idle_pct = 0;

    sorted_priority_queue_top #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_item_value   (i_item_value),
        .i_item_priority(i_item_priority),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_entry_count  (o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    // Apply one request to the shadow queue and return the answer it should give
    function automatic t_queue_answer serve_request(t_queue_request r);
        t_queue_answer a;
        int            pos;
        a.status = ST_OK;
        a.value  = '0;
        a.prio   = '0;
        if (r.cmd == CMD_INSERT) begin
            if (held_count >= DEPTH) begin
                a.status = ST_OVERFLOW;
            end else begin
                // walk up from the tail past strictly lower priorities
                pos = held_count;
                while (pos > 0 && held_prio[pos-1] < r.prio) begin
                    held_value[pos] = held_value[pos-1];
                    held_prio[pos]  = held_prio[pos-1];
                    pos--;
                end
                held_value[pos] = r.value;
                held_prio[pos]  = r.prio;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                a.status = ST_UNDERFLOW;
            end else begin
                a.value = held_value[0];
                a.prio  = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1]  = held_prio[i];
                end
                held_count--;
            end
        end
        a.count = COUNT_OUT_W'(held_count);
        return a;
    endfunction

    task automatic add_request(t_cmd cmd, logic signed [VALUE_W-1:0] value,
                               logic signed [PRIO_W-1:0] prio, bit drain_first);
        t_queue_request r;
        r.cmd         = cmd;
        r.value       = value;
        r.prio        = prio;
        r.drain_first = drain_first;
        r.gap         = (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) ?
                        $urandom_range(1, 13) : 0;
        request_q.push_back(r);
    endtask

    // Driver: present queued requests, predict each one as it is accepted
    always @(posedge i_clk) begin
        bit go;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                answer_q.push_back(serve_request(drv_item));
                issued_count++;
                have_item = 1'b0;
            end
            if (!have_item && request_q.size() > 0) begin
                drv_item  = request_q.pop_front();
                have_item = 1'b1;
                gap_left  = drv_item.gap;
            end
            if (have_item) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(start && busy) && drv_item.drain_first &&
                             issued_count - answered_count - int'(o_strobe) > 0) begin
                    // hold off until the last answer has been seen
                end else begin
                    go = 1'b1;
                end
                i_cmd           <= drv_item.cmd;
                i_item_value    <= drv_item.value;
                i_item_priority <= drv_item.prio;
            end
            start <= go;
        end
    end

    // Monitor: compare each answer with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_answer want;
        if (i_rst_n && o_strobe) begin
            answered_count <= answered_count + 1;
            if (answer_q.size() == 0) begin
                $error("answer with no request outstanding");
                error_count++;
            end else begin
                want = answer_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_out_value !== want.value) begin
                    $error("out_value: expected %0d, got %0d", want.value, o_out_value);
                    error_count++;
                end
                if (o_out_priority !== want.prio) begin
                    $error("out_priority: expected %0d, got %0d", want.prio,
                           o_out_priority);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           o_entry_count);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int   seg_len;
        int   ins_pct;
        int   made;
        t_cmd cmd;
        logic signed [PRIO_W-1:0] prio;

        // directed: empty delete, extremes, ties, full, overflow, drain, underflow
        idle_pct = 20;
        add_request(CMD_DELETE, $urandom(), PRIO_W'($urandom()), 1'b0);
        add_request(CMD_INSERT, 32'sd0, 16'sd0, 1'b0);
        add_request(CMD_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b0);
        add_request(CMD_INSERT, 32'sh8000_0000, 16'sh8000, 1'b0);
        add_request(CMD_INSERT, -32'sd1, 16'sd0, 1'b0);
        add_request(CMD_INSERT, 32'sd1, 16'sh7FFF, 1'b0);
        add_request(CMD_INSERT, 32'sh5555_5555, -16'sd1, 1'b0);
        add_request(CMD_INSERT, 32'shAAAA_AAAA, 16'sd1, 1'b0);
        add_request(CMD_INSERT, 32'sd123, 16'sh8000, 1'b0);
        add_request(CMD_INSERT, -32'sd1, 16'sh7FFF, 1'b0);
        for (int i = 0; i < DEPTH; i++) begin
            add_request(CMD_DELETE, $urandom(), PRIO_W'($urandom()), i == 0);
        end
        add_request(CMD_DELETE, -32'sd1, -16'sd1, 1'b0);
        add_request(CMD_INSERT, $urandom(), PRIO_W'($urandom()), 1'b0);
        add_request(CMD_DELETE, 32'sd0, 16'sd0, 1'b0);

        // random: segments with their own insert bias and idle rate
        made = 0;
        while (made < 1600) begin
            seg_len = $urandom_range(20, 120);
            ins_pct = $urandom_range(15, 85);
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
            endcase
            for (int k = 0; k < seg_len && made < 1600; k++) begin
                // no idling near the end
                if (made >= 1400) idle_pct = 0;
                cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
                case ($urandom_range(0, 3))
                    0, 1: prio = PRIO_W'($urandom_range(0, 6)) - 16'sd3;
                    2: prio = PRIO_W'($urandom());
                    default: prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                endcase
                add_request(cmd, $urandom(), prio, $urandom_range(0, 99) == 0);
                made++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything accepted, every answer back, then a short tail
        while (request_q.size() != 0 || have_item) @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (error_count == 0 && answer_q.size() == 0) begin
            $display("PASS sorted_priority_queue_top");
        end else begin
            $display("FAIL sorted_priority_queue_top");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL sorted_priority_queue_top");
        $finish;
    end

endmodule
